// ----- hdl/qtok_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_pkg
// Shared types, character constants and helpers of the field tokenizer.
// ----------------------------------------------------------------------------
package qtok_pkg;

	localparam int MAX_FIELD_DEF = 64;
	localparam logic [6:0] FIELD_LIMIT_RST = 7'd64;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_QSKIP  = 2'd1,
		PH_QFIELD = 2'd2,
		PH_UFIELD = 2'd3
	} phase_t;

	// results owed for one input beat, apart from the pending flush
	typedef struct packed {
		logic [7:0] ch;
		logic       emit_char;
		logic       end_f;
		status_t    end_st;
		logic       none;
	} plan_t;

	// space, TAB, LF, VT, FF, CR
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ----- hdl/qtok_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qtok_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/qtok_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_step
// Per-beat decision: next field state, pending-store write and result plan.
// ----------------------------------------------------------------------------
module qtok_step import qtok_pkg::*; #(
	parameter int CW = 6,
	parameter int AW = 6
) (
	input  phase_t        phase,
	input  logic [7:0]    quote,
	input  logic [CW-1:0] fc,
	input  logic [CW-1:0] pc,
	input  logic          ovf,
	input  logic [CW:0]   kmax,
	input  logic [7:0]    char_in,
	input  logic          line_last,
	output phase_t        phase_d,
	output logic [7:0]    quote_d,
	output logic [CW-1:0] fc_d,
	output logic [CW-1:0] pc_d,
	output logic          ovf_d,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [CW-1:0] flush_n,
	output plan_t         plan
);

	logic ws;
	logic keep;

	assign ws = is_ws(char_in);

	always_comb begin
		phase_d = phase;
		quote_d = quote;
		fc_d    = fc;
		pc_d    = pc;
		ovf_d   = ovf;
		wr_en   = 1'b0;
		wr_addr = '0;
		flush_n = '0;
		plan    = '0;
		plan.ch = char_in;
		keep    = 1'b0;

		case (phase)
			PH_QSKIP: begin
				if (!ws) begin
					if (char_in == quote) begin
						plan.end_f  = 1'b1;
						plan.end_st = ST_OK;
						phase_d     = PH_SKIP;
						pc_d        = '0;
					end else begin
						phase_d = PH_QFIELD;
						keep    = 1'b1;
					end
				end
			end
			PH_QFIELD: begin
				if (char_in == quote) begin
					plan.end_f  = 1'b1;
					plan.end_st = ovf ? ST_FAIL : ST_OK;
					phase_d     = PH_SKIP;
					pc_d        = '0;
				end else begin
					keep = 1'b1;
				end
			end
			PH_UFIELD: begin
				if ((char_in == CH_SPACE) || (char_in == CH_TAB)) begin
					plan.end_f  = 1'b1;
					plan.end_st = ovf ? ST_FAIL : ST_OK;
					phase_d     = PH_SKIP;
					pc_d        = '0;
				end else begin
					keep = 1'b1;
				end
			end
			default: begin
				phase_d = PH_SKIP;
				if (!ws) begin
					fc_d  = '0;
					pc_d  = '0;
					ovf_d = 1'b0;
					if ((char_in == CH_DQUOTE) || (char_in == CH_SQUOTE)) begin
						quote_d = char_in;
						phase_d = PH_QSKIP;
					end else begin
						phase_d = PH_UFIELD;
						keep    = 1'b1;
					end
				end
			end
		endcase

		// keep a character: drop on overflow, park whitespace, else flush
		if (keep) begin
			if (({1'b0, fc_d} + {1'b0, pc_d}) >= kmax) begin
				ovf_d = 1'b1;
			end else if (ws) begin
				wr_en   = 1'b1;
				wr_addr = pc_d[AW-1:0];
				pc_d    = pc_d + 1'b1;
			end else begin
				flush_n        = pc_d;
				fc_d           = fc_d + pc_d + 1'b1;
				pc_d           = '0;
				plan.emit_char = 1'b1;
			end
		end

		// line end closes an open field, then the none report
		if (line_last) begin
			if ((phase_d == PH_QSKIP) || (phase_d == PH_QFIELD)) begin
				plan.end_f  = 1'b1;
				plan.end_st = ST_FAIL;
			end else if (phase_d == PH_UFIELD) begin
				plan.end_f  = 1'b1;
				plan.end_st = ovf_d ? ST_FAIL : ST_OK;
			end
			plan.none = 1'b1;
			phase_d   = PH_SKIP;
			pc_d      = '0;
		end
	end

endmodule

// ----- hdl/qtok_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_emit
// Result sequencer: replays pending whitespace from RAM, then the kept
// character, field end and none report, through one output register.
// ----------------------------------------------------------------------------
module qtok_emit import qtok_pkg::*; #(
	parameter int CW = 6,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  plan_t         plan,
	input  logic [CW-1:0] flush_n,
	output logic          busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    char_out,
	output logic          char_valid,
	output logic          field_end,
	output status_t       status,
	output logic          line_done
);

	typedef enum logic [2:0] {
		E_IDLE,
		E_RD,
		E_WAIT,
		E_CHAR,
		E_END,
		E_NONE
	} emit_state_t;

	emit_state_t   state_q;
	plan_t         plan_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_nx;
	logic          can_load;
	logic          ld_out;

	function automatic emit_state_t tail(input logic end_f, input logic none);
		if (end_f) begin
			return E_END;
		end else if (none) begin
			return E_NONE;
		end
		return E_IDLE;
	endfunction

	assign can_load = !out_valid || !out_stall;
	// a result beat enters the output register this cycle
	assign ld_out   = can_load && ((state_q == E_WAIT) || (state_q == E_CHAR) ||
		(state_q == E_END) || (state_q == E_NONE));
	assign idx_nx   = idx_q + 1'b1;
	assign busy     = (state_q != E_IDLE);
	assign rd_en    = (state_q == E_RD);
	assign rd_addr  = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= E_IDLE;
			plan_q     <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			out_valid  <= 1'b0;
			char_out   <= '0;
			char_valid <= 1'b0;
			field_end  <= 1'b0;
			status     <= ST_OK;
			line_done  <= 1'b0;
		end else begin
			if (ld_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (start) begin
						plan_q <= plan;
						cnt_q  <= flush_n;
						idx_q  <= '0;
						if (flush_n != '0) begin
							state_q <= E_RD;
						end else if (plan.emit_char) begin
							state_q <= E_CHAR;
						end else begin
							state_q <= tail(plan.end_f, plan.none);
						end
					end
				end
				E_RD: begin
					state_q <= E_WAIT;
				end
				E_WAIT: begin
					if (can_load) begin
						char_out   <= rd_data;
						char_valid <= 1'b1;
						field_end  <= 1'b0;
						status     <= ST_OK;
						line_done  <= 1'b0;
						idx_q      <= idx_nx;
						state_q    <= (idx_nx == cnt_q) ? E_CHAR : E_RD;
					end
				end
				E_CHAR: begin
					if (can_load) begin
						char_out   <= plan_q.ch;
						char_valid <= 1'b1;
						field_end  <= 1'b0;
						status     <= ST_OK;
						line_done  <= 1'b0;
						state_q    <= tail(plan_q.end_f, plan_q.none);
					end
				end
				E_END: begin
					if (can_load) begin
						char_out   <= '0;
						char_valid <= 1'b0;
						field_end  <= 1'b1;
						status     <= plan_q.end_st;
						line_done  <= 1'b0;
						state_q    <= plan_q.none ? E_NONE : E_IDLE;
					end
				end
				E_NONE: begin
					if (can_load) begin
						char_out   <= '0;
						char_valid <= 1'b0;
						field_end  <= 1'b1;
						status     <= ST_NONE;
						line_done  <= 1'b1;
						state_q    <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/quoted_text_field_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_text_field_tokenizer
// Splits a text line, one byte per input beat, into whitespace-separated or
// quoted fields, with trailing-whitespace trim held in a pending RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in      | in  | in_valid/in_stall  | char_in[7:0], line_last
//  out     | out | out_valid/out_stall| char_out[7:0], char_valid, field_end,
//          |     |                    | status[1:0], line_done
//  cfg     | in  | cfg_valid/cfg_ready| field_limit[6:0]
//
//  An input beat is taken when the sequencer is idle; its results then leave
//  one per cycle unless the output stalls, except that each pending whitespace
//  byte takes a RAM read, then an output load. Reset is asynchronous; the
//  pending RAM needs no clearing pass, as only entries below the pending count
//  are read. A held result in the output register does not block acceptance
//  of the next beat once sequencing ends.
//  cfg_ready is always high; writes are expected only while idle.
//
module quoted_text_field_tokenizer import qtok_pkg::*; #(
	parameter int MAX_FIELD = MAX_FIELD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       line_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       char_valid,
	output logic       field_end,
	output logic [1:0] status,
	output logic       line_done,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] field_limit
);

	// counts reach at most MAX_FIELD-1; pending RAM has MAX_FIELD-1 entries
	localparam int CW    = $clog2(MAX_FIELD);
	localparam int DEPTH = MAX_FIELD - 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [6:0]    field_limit_q;
	phase_t        phase_q;
	logic [7:0]    quote_q;
	logic [CW-1:0] fc_q;
	logic [CW-1:0] pc_q;
	logic          ovf_q;
	logic [CW:0]   kmax;

	phase_t        phase_d;
	logic [7:0]    quote_d;
	logic [CW-1:0] fc_d;
	logic [CW-1:0] pc_d;
	logic          ovf_d;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] flush_n;
	plan_t         plan;

	logic          accept;
	logic          busy;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	status_t       status_e;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign accept    = in_valid && !busy;
	assign status    = status_e;

	// most characters a field may keep: clamp limit to [2, MAX_FIELD], minus one
	always_comb begin
		if (field_limit_q < 7'd2) begin
			kmax = (CW+1)'(1);
		end else if (int'(field_limit_q) > MAX_FIELD) begin
			kmax = (CW+1)'(MAX_FIELD - 1);
		end else begin
			kmax = (CW+1)'(field_limit_q - 7'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q <= FIELD_LIMIT_RST;
			phase_q       <= PH_SKIP;
			quote_q       <= '0;
			fc_q          <= '0;
			pc_q          <= '0;
			ovf_q         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				field_limit_q <= field_limit;
			end
			// all field state moves in the accept cycle; results follow
			if (accept) begin
				phase_q <= phase_d;
				quote_q <= quote_d;
				fc_q    <= fc_d;
				pc_q    <= pc_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	qtok_step #(
		.CW(CW),
		.AW(AW)
	) u_step (
		.phase    (phase_q),
		.quote    (quote_q),
		.fc       (fc_q),
		.pc       (pc_q),
		.ovf      (ovf_q),
		.kmax     (kmax),
		.char_in  (char_in),
		.line_last(line_last),
		.phase_d  (phase_d),
		.quote_d  (quote_d),
		.fc_d     (fc_d),
		.pc_d     (pc_d),
		.ovf_d    (ovf_d),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.flush_n  (flush_n),
		.plan     (plan)
	);

	// pending whitespace store; written only on an accepted beat
	qtok_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_pend (
		.clk  (clk),
		.we   (wr_en && accept),
		.waddr(wr_addr),
		.wdata(char_in),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	qtok_emit #(
		.CW(CW),
		.AW(AW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.plan      (plan),
		.flush_n   (flush_n),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.char_valid(char_valid),
		.field_end (field_end),
		.status    (status_e),
		.line_done (line_done)
	);

endmodule

// ----- hdl/qtok_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtok_checker
// Port-level checks of the field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module qtok_checker import qtok_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] char_in,
	input logic       line_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] char_out,
	input logic       char_valid,
	input logic       field_end,
	input logic [1:0] status,
	input logic       line_done,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [6:0] field_limit
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(char_valid)
			&& $stable(field_end) && $stable(status) && $stable(line_done))
		else $error("stalled result beat changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(char_valid && field_end))
		else $error("result is both character and field end");

	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> field_end && (status == ST_NONE))
		else $error("line_done without none report");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !field_end |-> (status == ST_OK) && !line_done)
		else $error("status set on character beat");

	// a line end always owes a none report, so input must stall next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && line_last |=> in_stall)
		else $error("input taken while none report pending");

endmodule

bind quoted_text_field_tokenizer qtok_checker u_qtok_checker (.*);
